>>> rtl/afb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afb_pkg: shared types and constants
// Frame layout positions, byte constants and the converter-to-emitter bundle.
// ---------------------------------------------------------------------------
package afb_pkg;

	localparam int VALUE_W = 32;
	localparam int NDIG    = 10;              // decimal digits of a 32-bit magnitude
	localparam int CNT_W   = $clog2(VALUE_W);
	localparam int DPTR_W  = $clog2(NDIG);
	localparam int IDX_W   = 5;               // frame position, up to 28

	localparam logic [7:0] BYTE_START   = 8'h7E;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] BYTE_TYPE_TX = 8'h10;
	localparam logic [7:0] BYTE_BCAST_H = 8'hFF;
	localparam logic [7:0] BYTE_BCAST_L = 8'hFE;
	localparam logic [7:0] BYTE_MINUS   = 8'h2D;
	localparam logic [3:0] ASCII_DIGIT  = 4'h3;
	localparam logic [7:0] LEN_OVERHEAD = 8'd14;
	localparam logic [7:0] CSUM_FULL    = 8'hFF;
	// low byte of 0x10 + 0xFF + 0xFE
	localparam logic [7:0] SUM_INIT     = 8'h0D;

	// start, length (2), type, id, address (5..12), FF, FE, radius, options
	localparam logic [IDX_W-1:0] IDX_START  = 5'd0;
	localparam logic [IDX_W-1:0] IDX_LEN_LO = 5'd2;
	localparam logic [IDX_W-1:0] IDX_TYPE   = 5'd3;
	localparam logic [IDX_W-1:0] IDX_BC_H   = 5'd13;
	localparam logic [IDX_W-1:0] IDX_BC_L   = 5'd14;
	localparam logic [IDX_W-1:0] IDX_PAY    = 5'd17;

	typedef logic [NDIG-1:0][3:0] bcd_t;

	typedef struct packed {
		logic done;
		logic neg;
		bcd_t digits;
	} conv_t;

endpackage

>>> rtl/afb_bcd.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afb_bcd: iterative binary to BCD converter
// Shift-and-add-3 over the 32 magnitude bits, one magnitude bit per cycle.
// ---------------------------------------------------------------------------
module afb_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [afb_pkg::VALUE_W-1:0] value,
	output logic                        busy,
	output afb_pkg::conv_t              conv
);
	import afb_pkg::*;

	typedef enum logic {ST_IDLE, ST_SHIFT} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] mag_q;
	logic [CNT_W-1:0]   cnt_q;
	bcd_t               bcd_q;
	logic               neg_q;
	logic               done_q;
	bcd_t               adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q   <= '0;
			cnt_q   <= '0;
			bcd_q   <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						neg_q   <= value[VALUE_W-1];
						mag_q   <= value[VALUE_W-1] ? (~value + 1'b1) : value;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// top digit never overflows for a 32-bit magnitude
					bcd_q <= {adj[NDIG-1][2:0], adj[NDIG-2:0], mag_q[VALUE_W-1]};
					mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VALUE_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q == ST_SHIFT);
	assign conv.done   = done_q;
	assign conv.neg    = neg_q;
	assign conv.digits = bcd_q;

endmodule

>>> rtl/afb_emit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afb_emit: frame byte sequencer
// Walks the frame one word per cycle, summing payload for the checksum.
// ---------------------------------------------------------------------------
module afb_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  afb_pkg::conv_t conv,
	output logic           busy,
	output logic           strobe,
	output logic [7:0]     frame_byte,
	output logic           last
);
	import afb_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  end_q;
	logic [3:0]        plen_q;
	logic [DPTR_W-1:0] dptr_q;
	logic [7:0]        sum_q;
	logic              neg_q;
	bcd_t              dig_q;
	logic [7:0]        byte_q;
	logic              strobe_q;
	logic              last_q;

	logic [3:0]        nd;
	logic [3:0]        plen_d;
	logic              is_last;
	logic              is_pay;
	logic              is_minus;
	logic [7:0]        byte_d;

	// count of significant digits, at least one
	always_comb begin
		nd = 4'd1;
		for (int i = 0; i < NDIG; i++) begin
			if (conv.digits[i] != 4'd0) nd = 4'(i + 1);
		end
		plen_d = nd + {3'b000, conv.neg};
	end

	always_comb begin
		is_last  = (idx_q == end_q);
		is_pay   = (idx_q >= IDX_PAY) && !is_last;
		is_minus = neg_q && (idx_q == IDX_PAY);
		if (is_last)
			byte_d = CSUM_FULL - sum_q;
		else if (is_minus)
			byte_d = BYTE_MINUS;
		else if (is_pay)
			byte_d = {ASCII_DIGIT, dig_q[dptr_q]};
		else if (idx_q == IDX_START)
			byte_d = BYTE_START;
		else if (idx_q == IDX_LEN_LO)
			byte_d = {4'h0, plen_q} + LEN_OVERHEAD;
		else if (idx_q == IDX_TYPE)
			byte_d = BYTE_TYPE_TX;
		else if (idx_q == IDX_BC_H)
			byte_d = BYTE_BCAST_H;
		else if (idx_q == IDX_BC_L)
			byte_d = BYTE_BCAST_L;
		else
			byte_d = BYTE_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			end_q    <= '0;
			plen_q   <= '0;
			dptr_q   <= '0;
			sum_q    <= '0;
			neg_q    <= 1'b0;
			dig_q    <= '0;
			byte_q   <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (conv.done) begin
						dig_q   <= conv.digits;
						neg_q   <= conv.neg;
						plen_q  <= plen_d;
						end_q   <= IDX_PAY + IDX_W'(plen_d);
						dptr_q  <= DPTR_W'(nd - 4'd1);
						sum_q   <= SUM_INIT;
						idx_q   <= IDX_START;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					byte_q   <= byte_d;
					strobe_q <= 1'b1;
					last_q   <= is_last;
					idx_q    <= idx_q + 1'b1;
					if (is_pay) sum_q <= sum_q + byte_d;
					if (is_pay && !is_minus) dptr_q <= dptr_q - 1'b1;
					if (is_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q == ST_RUN);
	assign strobe     = strobe_q;
	assign frame_byte = byte_q;
	assign last       = last_q;

endmodule

>>> rtl/api_transmit_frame_builder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// api_transmit_frame_builder: transmit-request frame (type 0x10) generator
// The first frame word follows the BCD loop and the hand-off; words then run back to back.
// A frame is 19 to 29 words; busy stays high from start to the last word,
// so the next value is taken only once the 32-step BCD loop and that frame are done.
// Async reset clears the sequencers; strobe is low and busy low after reset.
// The receiver cannot stall: each word is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module api_transmit_frame_builder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [afb_pkg::VALUE_W-1:0] value,
	output logic                        busy,
	output logic                        strobe,
	output logic [7:0]                  frame_byte,
	output logic                        last
);
	import afb_pkg::*;

	conv_t conv;
	logic  bcd_busy;
	logic  emit_busy;

	afb_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (start && !busy),
		.value  (value),
		.busy   (bcd_busy),
		.conv   (conv)
	);

	afb_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv       (conv),
		.busy       (emit_busy),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last       (last)
	);

	// conv.done covers the hand-off cycle between the two units
	assign busy = bcd_busy || conv.done || emit_busy;

endmodule

>>> rtl/afb_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afb_checker: port-level checks
// Frame framing and start/busy interplay seen at the top level.
// ---------------------------------------------------------------------------
module afb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] frame_byte,
	input logic       last
);
	import afb_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after start");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !strobe)
		else $error("word strobed right after start");

	a_frame_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a frame");

	a_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> (frame_byte == BYTE_START))
		else $error("frame does not open with start word");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

endmodule

bind api_transmit_frame_builder afb_checker u_afb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.frame_byte (frame_byte),
	.last       (last)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for api_transmit_frame_builder
// Drives signed values through the start/busy port and checks every frame word
// against a local frame predictor: directed corner values first, then random
// values spread over all digit counts, under several sender idle patterns.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HI       = 6;
	localparam int CLK_LO       = 6;
	localparam int RST_CYCLES   = 9;
	localparam int RAND_ITEMS   = 230;
	localparam int NUM_PHASES   = 3;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 50;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] TX_TYPE    = 8'h10;
	localparam logic [7:0] DEST_H     = 8'hFF;
	localparam logic [7:0] DEST_L     = 8'hFE;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] LEN_ADD    = 8'd14;
	localparam logic [7:0] CSUM_BASE  = 8'hFF;

	typedef logic [afb_pkg::VALUE_W-1:0] value_t;

	typedef struct {
		logic [7:0] data;
		logic       eof;
	} frame_word_t;

	typedef struct {
		value_t     v;
		bit         typed;    // length and checksum typed in below
		logic [7:0] len_lo;
		logic [7:0] csum;
	} stim_row_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	value_t            value  = '0;
	logic              busy;
	logic              strobe;
	logic [7:0]        frame_byte;
	logic              last;

	frame_word_t       frame_q[$];
	int                errors = 0;
	int                cycles = 0;

	// sender idle percentage per random phase; the receiver cannot stall
	int                idle_pct[NUM_PHASES] = '{0, 72, 14};

	stim_row_t dir_rows[20] = '{
		'{32'd0,            1'b1, 8'h0F, 8'hC2},
		'{32'd1,            1'b1, 8'h0F, 8'hC1},
		'{-32'sd1,          1'b1, 8'h10, 8'h94},
		'{32'h7FFF_FFFF,    1'b1, 8'h18, 8'hE4},
		'{32'h8000_0000,    1'b1, 8'h19, 8'hB6},
		'{32'h8000_0001,    1'b0, 8'h00, 8'h00},
		'{32'h7FFF_FFFE,    1'b0, 8'h00, 8'h00},
		'{32'd9,            1'b0, 8'h00, 8'h00},
		'{32'd10,           1'b0, 8'h00, 8'h00},
		'{-32'sd10,         1'b0, 8'h00, 8'h00},
		'{32'd99,           1'b0, 8'h00, 8'h00},
		'{32'd100,          1'b0, 8'h00, 8'h00},
		'{32'd12345,        1'b0, 8'h00, 8'h00},
		'{-32'sd654321,     1'b0, 8'h00, 8'h00},
		'{32'd123456789,    1'b0, 8'h00, 8'h00},
		'{-32'sd123456789,  1'b0, 8'h00, 8'h00},
		'{32'd999999999,    1'b0, 8'h00, 8'h00},
		'{-32'sd999999999,  1'b0, 8'h00, 8'h00},
		'{32'd1000000000,   1'b0, 8'h00, 8'h00},
		'{32'hAAAA_AAAA,    1'b0, 8'h00, 8'h00}
	};

	api_transmit_frame_builder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last       (last)
	);

	always begin
		#CLK_HI clk = 1'b0;
		#CLK_LO clk = 1'b1;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		end
	endtask

	function automatic void put_word(input logic [7:0] data, input logic eof);
		frame_word_t w;
		w.data = data;
		w.eof  = eof;
		frame_q.push_back(w);
	endfunction

	// Queue the whole frame for one value; typed rows override length and checksum.
	function automatic void predict_frame(input value_t v, input bit typed,
			input logic [7:0] len_lo, input logic [7:0] csum);
		logic       neg;
		value_t     mag;
		logic [7:0] digs[10];
		logic [7:0] text[$];
		logic [7:0] sum;
		int         nd;
		neg = v[afb_pkg::VALUE_W-1];
		mag = neg ? (~v + 32'd1) : v;    // most negative value stays 0x80000000
		nd  = 0;
		do begin
			digs[nd] = DIGIT_BASE + 8'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		if (neg) begin
			text.push_back(MINUS_CHAR);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			text.push_back(digs[i]);
		end
		sum = TX_TYPE + DEST_H + DEST_L;
		foreach (text[i]) begin
			sum += text[i];
		end
		put_word(START_BYTE, 1'b0);
		put_word(ZERO_BYTE, 1'b0);
		put_word(typed ? len_lo : 8'(text.size()) + LEN_ADD, 1'b0);
		put_word(TX_TYPE, 1'b0);
		put_word(ZERO_BYTE, 1'b0);
		for (int i = 0; i < 8; i++) begin
			put_word(ZERO_BYTE, 1'b0);
		end
		put_word(DEST_H, 1'b0);
		put_word(DEST_L, 1'b0);
		put_word(ZERO_BYTE, 1'b0);
		put_word(ZERO_BYTE, 1'b0);
		foreach (text[i]) begin
			put_word(text[i], 1'b0);
		end
		put_word(typed ? csum : CSUM_BASE - sum, 1'b1);
	endfunction

	// Mostly picks a digit count first so short and long payloads both show up.
	function automatic value_t rand_value();
		longint lo;
		longint hi;
		longint mag;
		int     nd;
		if ($urandom_range(3) == 0) begin
			return $urandom();
		end
		nd  = $urandom_range(1, 10);
		lo  = (nd == 1) ? 0 : 10 ** (nd - 1);
		hi  = (nd == 10) ? 64'd2147483647 : 10 ** nd - 1;
		mag = $urandom_range(32'(hi), 32'(lo));
		return $urandom_range(1) ? value_t'(-mag) : value_t'(mag);
	endfunction

	task automatic send_value(input value_t v, input bit typed, input logic [7:0] len_lo,
			input logic [7:0] csum, input int idle);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		predict_frame(v, typed, len_lo, csum);
		if ($urandom_range(99) < idle) begin
			start <= 1'b0;
			value <= $urandom();
			repeat ($urandom_range(80, 1)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_words
		frame_word_t want;
		if (arst_n && strobe) begin
			if (frame_q.size() == 0) begin
				report_mismatch("unexpected word", frame_byte, 8'h00);
			end else begin
				want = frame_q.pop_front();
				if (frame_byte !== want.data) begin
					report_mismatch("frame_byte", frame_byte, want.data);
				end
				if (last !== want.eof) begin
					report_mismatch("last", {7'd0, last}, {7'd0, want.eof});
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("api_transmit_frame_builder test failed");
			$finish;
		end
	end

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_value(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].len_lo,
				dir_rows[i].csum, 0);
		end
		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
				send_value(rand_value(), 1'b0, 8'h00, 8'h00, idle_pct[p]);
			end
		end
		start <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("api_transmit_frame_builder test passed");
		end else begin
			$display("api_transmit_frame_builder test failed");
		end
		$finish;
	end

endmodule

>>> api_transmit_frame_builder.f
rtl/afb_pkg.sv
rtl/afb_bcd.sv
rtl/afb_emit.sv
rtl/api_transmit_frame_builder.sv
rtl/afb_checker.sv
verif/tb_top.sv
